>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define RASS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define RASS_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define RASS_ASSERT(lbl, clk, rst, prop, msg)
`define RASS_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

>>> rtl/rass_pkg.sv
package rass_pkg;

  localparam int WORD_W    = 32;
  localparam int ROT_TRIES = 31;
  localparam int GROUP_SZ  = 4;
  localparam int GROUPS    = (ROT_TRIES + GROUP_SZ - 1) / GROUP_SZ;
  localparam int NUM_WORDS = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [5:0]        cnt_t;
  typedef logic [4:0]        rot_t;
  typedef logic [1:0]        cfg_idx_t;

  // Register indexes on the config port
  localparam cfg_idx_t CFG_FIXED_EN    = 2'd0;
  localparam cfg_idx_t CFG_FIXED_SHIFT = 2'd1;
  localparam cfg_idx_t CFG_ZERO_PREFIX = 2'd2;

  localparam logic [1:0] SEEN_FULL   = 2'd3;
  localparam cnt_t       NO_ROT      = 6'd32;
  localparam cnt_t       FULL_WT     = 6'd32;
  localparam cnt_t       PREFIX_RST  = 6'd12;

  // Load enables for the pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic so;
  } stage_en_t;

  // Left rotate; a rotation of zero is the identity
  function automatic word_t rotl32(input word_t x, input rot_t r);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << r;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

  function automatic cnt_t popcnt32(input word_t x);
    cnt_t n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) n = n + cnt_t'(x[i]);
    return n;
  endfunction

  // 5 * ceil(r / 5) for r in 0..32
  function automatic cnt_t round_up5(input cnt_t r);
    cnt_t res;
    res = 6'd35;
    for (int k = 7; k >= 0; k--) begin
      if (r <= cnt_t'(5 * k)) res = cnt_t'(5 * k);
    end
    return res;
  endfunction

  // Top 'bits' bits of x are zero; bits outside 1..32 never pass
  function automatic logic prefix_clear(input word_t x, input cnt_t bits);
    word_t mask;
    mask = ~({WORD_W{1'b1}} >> bits);
    return (bits != '0) && (bits <= 6'd32) && ((x & mask) == '0);
  endfunction

endpackage

>>> rtl/rass_lane.sv
// One rotation lane: Hamming distance of rotated previous word to current word.
module rass_lane
  import rass_pkg::*;
#(
  parameter int ROT = 0
) (
  input  logic      clk,
  input  stage_en_t en,
  input  word_t     prev,
  input  word_t     cur,
  output cnt_t      hdist
);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      hdist <= popcnt32(rotl32(prev, rot_t'(ROT)) ^ cur);
    end
  end

endmodule

>>> rtl/rass_merge.sv
// Two-level registered minimum tree over the lane distances, first minimum wins.
module rass_merge
  import rass_pkg::*;
(
  input  logic      clk,
  input  stage_en_t en,
  input  cnt_t      hdist [ROT_TRIES],
  output cnt_t      best_rot,
  output cnt_t      best_wt
);

  cnt_t grp_wt      [GROUPS];
  rot_t grp_rot     [GROUPS];
  cnt_t grp_wt_next [GROUPS];
  rot_t grp_rot_next[GROUPS];
  cnt_t fin_wt;
  rot_t fin_rot;

  // First level: minimum inside each group of lanes
  always_comb begin
    cnt_t w;
    rot_t r;
    for (int g = 0; g < GROUPS; g++) begin
      w = hdist[g*GROUP_SZ];
      r = rot_t'(g*GROUP_SZ);
      for (int j = 1; j < GROUP_SZ; j++) begin
        if (g*GROUP_SZ + j < ROT_TRIES) begin
          if (hdist[g*GROUP_SZ + j] < w) begin
            w = hdist[g*GROUP_SZ + j];
            r = rot_t'(g*GROUP_SZ + j);
          end
        end
      end
      grp_wt_next[g]  = w;
      grp_rot_next[g] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      grp_wt  <= grp_wt_next;
      grp_rot <= grp_rot_next;
    end
  end

  // Second level: minimum over groups, earlier group wins ties
  always_comb begin
    fin_wt  = grp_wt[0];
    fin_rot = grp_rot[0];
    for (int g = 1; g < GROUPS; g++) begin
      if (grp_wt[g] < fin_wt) begin
        fin_wt  = grp_wt[g];
        fin_rot = grp_rot[g];
      end
    end
  end

  // No distance below full weight reports the out-of-range rotation
  always_ff @(posedge clk) begin
    if (en.s4) begin
      best_wt  <= fin_wt;
      best_rot <= (fin_wt == FULL_WT) ? NO_ROT : {1'b0, fin_rot};
    end
  end

endmodule

>>> rtl/rass_resid.sv
// Residual after applying the chosen rotation, its weight and the prefix test.
module rass_resid
  import rass_pkg::*;
(
  input  logic      clk,
  input  stage_en_t en,
  input  word_t     prev,
  input  word_t     cur,
  input  cnt_t      best_rot_in,
  input  cnt_t      best_wt_in,
  input  logic      fixed_shift_enable,
  input  rot_t      fixed_shift,
  input  cnt_t      zero_prefix_bits,
  output cnt_t      best_rot,
  output cnt_t      best_wt,
  output cnt_t      used_rot,
  output cnt_t      resid_wt,
  output logic      pass
);

  cnt_t  used_next;
  word_t resid;

  assign used_next = fixed_shift_enable ? {1'b0, fixed_shift} : round_up5(best_rot_in);
  // rotation taken mod 32
  assign resid     = rotl32(prev, used_next[4:0]) ^ cur;

  always_ff @(posedge clk) begin
    if (en.so) begin
      best_rot <= best_rot_in;
      best_wt  <= best_wt_in;
      used_rot <= used_next;
      resid_wt <= popcnt32(resid);
      pass     <= prefix_clear(resid, zero_prefix_bits);
    end
  end

endmodule

>>> rtl/rotation_aligned_sample_screen.sv
// Pipeline: an accepted item moves through stage registers v1, v2, v3 and v4 to out_valid;
// it may wait in the input skid first, and out_stall holds a full pipe.
// Throughput: one item per cycle unless out_stall holds a full pipe; 31 rotation lanes
// per word run in parallel and a two-level registered minimum tree merges them.
// Input stall comes from the skid register only, so it never follows out_stall directly.
// Reset (rst, synchronous): pipeline empty, previous words zero, sample count zero,
// fixed shift off, shift 0, prefix length 12.
`include "assert_macros.svh"

module rotation_aligned_sample_screen
  import rass_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word_a,
  input  logic [31:0] word_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [19:0] symbols_a,
  output logic [19:0] symbols_b,
  output logic [5:0]  best_rot_a,
  output logic [5:0]  best_wt_a,
  output logic [5:0]  used_rot_a,
  output logic [5:0]  resid_wt_a,
  output logic [5:0]  best_rot_b,
  output logic [5:0]  best_wt_b,
  output logic [5:0]  used_rot_b,
  output logic [5:0]  resid_wt_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  // Config registers
  logic fixed_shift_enable;
  rot_t fixed_shift;
  cnt_t zero_prefix_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_shift_enable <= 1'b0;
      fixed_shift        <= '0;
      zero_prefix_bits   <= PREFIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIXED_EN:    fixed_shift_enable <= cfg_data[0];
        CFG_FIXED_SHIFT: fixed_shift        <= cfg_data[4:0];
        CFG_ZERO_PREFIX: zero_prefix_bits   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables, bubbles collapse
  logic      v1, v2, v3, v4;
  logic      en1, en2, en3, en4, en_o;
  stage_en_t en;

  assign en_o  = !out_valid || !out_stall;
  assign en4   = !v4 || en_o;
  assign en3   = !v3 || en4;
  assign en2   = !v2 || en3;
  assign en1   = !v1 || en2;
  assign en.s2 = en2;
  assign en.s3 = en3;
  assign en.s4 = en4;
  assign en.so = en_o;

  // Input skid
  logic  skid_valid;
  word_t skid_w [NUM_WORDS];
  logic  in_acc;
  logic  src_valid;
  word_t src_w  [NUM_WORDS];

  assign in_stall  = skid_valid;
  assign in_acc    = in_valid && !in_stall;
  assign src_valid = skid_valid || in_valid;
  assign src_w[0]  = skid_valid ? skid_w[0] : word_a;
  assign src_w[1]  = skid_valid ? skid_w[1] : word_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      skid_valid <= !en1;
    end else if (in_acc && !en1) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && in_acc && !en1) begin
      skid_w[0] <= word_a;
      skid_w[1] <= word_b;
    end
  end

  // Previous words and sample count, updated as items enter the pipe
  word_t      prev_w [NUM_WORDS];
  logic [1:0] seen_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_w[0]  <= '0;
      prev_w[1]  <= '0;
      seen_count <= '0;
    end else if (en1 && src_valid) begin
      prev_w     <= src_w;
      if (seen_count != SEEN_FULL) seen_count <= seen_count + 2'd1;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)  v1        <= src_valid;
      if (en2)  v2        <= v1;
      if (en3)  v3        <= v2;
      if (en4)  v4        <= v3;
      if (en_o) out_valid <= v4;
    end
  end

  // Payload carried along the stages
  word_t prev1 [NUM_WORDS], cur1 [NUM_WORDS];
  word_t prev2 [NUM_WORDS], cur2 [NUM_WORDS];
  word_t prev3 [NUM_WORDS], cur3 [NUM_WORDS];
  word_t prev4 [NUM_WORDS], cur4 [NUM_WORDS];
  logic  seen1, seen2, seen3, seen4, seen_o;
  word_t cur_o [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (en1) begin
      prev1 <= prev_w;
      cur1  <= src_w;
      seen1 <= (seen_count == SEEN_FULL);
    end
    if (en2) begin
      prev2 <= prev1;
      cur2  <= cur1;
      seen2 <= seen1;
    end
    if (en3) begin
      prev3 <= prev2;
      cur3  <= cur2;
      seen3 <= seen2;
    end
    if (en4) begin
      prev4 <= prev3;
      cur4  <= cur3;
      seen4 <= seen3;
    end
    if (en_o) begin
      cur_o  <= cur4;
      seen_o <= seen4;
    end
  end

  // Per-word lanes, merge tree and residual
  cnt_t hdist    [NUM_WORDS][ROT_TRIES];
  cnt_t best_rot4[NUM_WORDS];
  cnt_t best_wt4 [NUM_WORDS];
  cnt_t best_rot_o[NUM_WORDS];
  cnt_t best_wt_o [NUM_WORDS];
  cnt_t used_rot_o[NUM_WORDS];
  cnt_t resid_wt_o[NUM_WORDS];
  logic pass_o    [NUM_WORDS];

  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
    for (genvar r = 0; r < ROT_TRIES; r++) begin : g_lane
      rass_lane #(.ROT(r)) u_lane (
        .clk   (clk),
        .en    (en),
        .prev  (prev1[w]),
        .cur   (cur1[w]),
        .hdist (hdist[w][r])
      );
    end

    rass_merge u_merge (
      .clk      (clk),
      .en       (en),
      .hdist    (hdist[w]),
      .best_rot (best_rot4[w]),
      .best_wt  (best_wt4[w])
    );

    rass_resid u_resid (
      .clk                (clk),
      .en                 (en),
      .prev               (prev4[w]),
      .cur                (cur4[w]),
      .best_rot_in        (best_rot4[w]),
      .best_wt_in         (best_wt4[w]),
      .fixed_shift_enable (fixed_shift_enable),
      .fixed_shift        (fixed_shift),
      .zero_prefix_bits   (zero_prefix_bits),
      .best_rot           (best_rot_o[w]),
      .best_wt            (best_wt_o[w]),
      .used_rot           (used_rot_o[w]),
      .resid_wt           (resid_wt_o[w]),
      .pass               (pass_o[w])
    );
  end

  // Output fields
  assign accepted   = seen_o && pass_o[0] && pass_o[1];
  assign symbols_a  = cur_o[0][24:5];
  assign symbols_b  = cur_o[1][24:5];
  assign best_rot_a = best_rot_o[0];
  assign best_wt_a  = best_wt_o[0];
  assign used_rot_a = used_rot_o[0];
  assign resid_wt_a = resid_wt_o[0];
  assign best_rot_b = best_rot_o[1];
  assign best_wt_b  = best_wt_o[1];
  assign used_rot_b = used_rot_o[1];
  assign resid_wt_b = resid_wt_o[1];

  // Checks
  `RASS_ASSERT(a_skid_drains, clk, rst, skid_valid && en1 |=> !skid_valid, "skid refilled while draining")
  `RASS_ASSERT(a_no_rot_full_wt, clk, rst, out_valid && best_rot_a == NO_ROT |-> best_wt_a == FULL_WT, "no-rotation marker with low weight")
  `RASS_ASSERT(a_accept_wt_a, clk, rst, out_valid && accepted |-> resid_wt_a <= FULL_WT - zero_prefix_bits, "accepted item with heavy residual a")
  `RASS_ASSERT(a_accept_wt_b, clk, rst, out_valid && accepted |-> resid_wt_b <= FULL_WT - zero_prefix_bits, "accepted item with heavy residual b")

endmodule
